// File: rtl/core/phasic_gated_laser_stimulator_top_macros.svh
// Assertion shorthands for the stimulator RTL.
`ifndef PHASIC_GATED_LASER_STIMULATOR_TOP_MACROS_SVH
`define PHASIC_GATED_LASER_STIMULATOR_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off while in reset.
`define PGLS_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off while in reset.
`define PGLS_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/pgls_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pgls_pkg;

  localparam int DEF_SAMPLE_BITS = 12;
  localparam int DEF_DAC_BITS    = 12;
  localparam int DEF_COUNT_BITS  = 24;
  localparam int DEF_RAMP_STEPS  = 64;

  localparam int REG_IDX_W = 3;

  // Register reset values
  localparam int unsigned RST_ON_LEVEL     = 4095;
  localparam int unsigned RST_BASE_LEVEL   = 0;
  localparam int unsigned RST_RAMP_RATE    = 16777;
  localparam int unsigned RST_PULSE_TICKS  = 10000;
  localparam int unsigned RST_PERIOD_TICKS = 100000;

  localparam logic [63:0] Q30_ONE = 64'd1 << 30;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_STIM_MODE    = 3'd0,
    REG_RAMP_SHAPE   = 3'd1,
    REG_ON_LEVEL     = 3'd2,
    REG_BASE_LEVEL   = 3'd3,
    REG_RAMP_RATE    = 3'd4,
    REG_PULSE_TICKS  = 3'd5,
    REG_PERIOD_TICKS = 3'd6
  } pgls_reg_e;

  typedef enum logic [1:0] {
    MODE_HIGH_GATE  = 2'd0,
    MODE_LOW_GATE   = 2'd1,
    MODE_LOW_TRAIN  = 2'd2,
    MODE_FREE_TRAIN = 2'd3
  } pgls_mode_e;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_GRISE = 3'd1,
    PH_GON   = 3'd2,
    PH_PRISE = 3'd3,
    PH_PHOLD = 3'd4,
    PH_FALL  = 3'd5
  } pgls_phase_e;

  typedef struct packed {
    logic        pend;
    pgls_phase_e phase;
  } pgls_stat_t;

  // Restoring long division, used only to build constant tables.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Sigmoid entry in units of 2^-dac_bits: exp() from a 4th order series of x/64,
  // then squared six times, all in Q30.
  function automatic logic [63:0] sig_entry(input int unsigned idx, input int unsigned steps,
                                            input int unsigned dac_bits);
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] p;
    logic [63:0] y;
    logic [63:0] y2;
    logic [63:0] y3;
    logic [63:0] y4;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] num;
    logic        pos;
    a   = 64'(idx) * 64'd10;
    b   = 64'(steps) * 64'd5;
    pos = (a >= b);
    p   = pos ? (a - b) : (b - a);
    y   = udiv64(p << 30, 64'(steps) * 64'd64);
    y2  = (y * y) >> 30;
    y3  = (y2 * y) >> 30;
    y4  = (y3 * y) >> 30;
    e   = (Q30_ONE + y2 / 64'd2 + y4 / 64'd24) - (y + y3 / 64'd6);
    for (int k = 0; k < 6; k++) begin
      e = (e * e) >> 30;
    end
    den = Q30_ONE + e;
    num = pos ? (Q30_ONE << dac_bits) : (e << dac_bits);
    return udiv64(num + (den >> 1), den);
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/pgls_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pgls_in_if #(
  parameter int SAMPLE_BITS = pgls_pkg::DEF_SAMPLE_BITS
) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] signal_sample;
  logic [SAMPLE_BITS-1:0] threshold_sample;
  logic                   enable;

  modport source (output valid, signal_sample, threshold_sample, enable, input ready);
  modport sink   (input valid, signal_sample, threshold_sample, enable, output ready);
endinterface

interface pgls_out_if #(
  parameter int DAC_BITS = pgls_pkg::DEF_DAC_BITS
) ();
  logic                valid;
  logic                ready;
  logic [DAC_BITS-1:0] dac_code;
  logic                light_on;
  logic                high_phase;
  logic                busy_res;

  modport source (output valid, dac_code, light_on, high_phase, busy_res, input ready);
  modport sink   (input valid, dac_code, light_on, high_phase, busy_res, output ready);
endinterface

`default_nettype wire

// File: rtl/core/pgls_ramp_shaper.sv
`timescale 1ns / 1ps
`default_nettype none

module pgls_ramp_shaper #(
  parameter int DAC_BITS   = pgls_pkg::DEF_DAC_BITS,
  parameter int COUNT_BITS = pgls_pkg::DEF_COUNT_BITS,
  parameter int RAMP_STEPS = pgls_pkg::DEF_RAMP_STEPS
) (
  input  logic [COUNT_BITS-1:0] acc_i,
  input  logic                  fall_i,
  input  logic [DAC_BITS-1:0]   on_level_i,
  input  logic [DAC_BITS-1:0]   base_level_i,
  output logic [DAC_BITS-1:0]   level_o
);

  localparam int IdxW  = $clog2(RAMP_STEPS);
  localparam int ProdW = COUNT_BITS + IdxW;
  localparam logic [DAC_BITS:0]     FullFrac = {1'b1, {DAC_BITS{1'b0}}};
  localparam logic [2*DAC_BITS:0]   Half     = (2*DAC_BITS+1)'(1) << (DAC_BITS - 1);

  logic [DAC_BITS:0]   sig_tab [RAMP_STEPS];
  logic [ProdW-1:0]    pos_prod;
  logic [IdxW-1:0]     idx;
  logic [DAC_BITS:0]   frac;
  logic                up;
  logic [DAC_BITS-1:0] diff;
  logic [2*DAC_BITS:0] scaled;
  logic [DAC_BITS-1:0] step;

  for (genvar g = 0; g < RAMP_STEPS; g++) begin : g_tab
    assign sig_tab[g] = (DAC_BITS+1)'(pgls_pkg::sig_entry(g, RAMP_STEPS, DAC_BITS));
  end

  always_comb begin
    pos_prod = ProdW'(acc_i) * ProdW'(RAMP_STEPS);
    idx      = pos_prod[ProdW-1:COUNT_BITS];
    frac     = fall_i ? (FullFrac - sig_tab[idx]) : sig_tab[idx];
    up       = (on_level_i >= base_level_i);
    diff     = up ? (on_level_i - base_level_i) : (base_level_i - on_level_i);
    scaled   = (2*DAC_BITS+1)'(diff) * (2*DAC_BITS+1)'(frac) + Half;
    step     = scaled[2*DAC_BITS-1:DAC_BITS];
    level_o  = up ? (base_level_i + step) : (base_level_i - step);
  end

endmodule

`default_nettype wire

// File: rtl/core/pgls_step_engine.sv
`timescale 1ns / 1ps
`default_nettype none

module pgls_step_engine #(
  parameter int SAMPLE_BITS = pgls_pkg::DEF_SAMPLE_BITS,
  parameter int DAC_BITS    = pgls_pkg::DEF_DAC_BITS,
  parameter int COUNT_BITS  = pgls_pkg::DEF_COUNT_BITS,
  parameter int RAMP_STEPS  = pgls_pkg::DEF_RAMP_STEPS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  pgls_in_if.sink               in_if,
  pgls_out_if.source            out_if,
  input  pgls_pkg::pgls_mode_e  stim_mode_i,
  input  logic                  ramp_shape_i,
  input  logic [DAC_BITS-1:0]   on_level_i,
  input  logic [DAC_BITS-1:0]   base_level_i,
  input  logic [COUNT_BITS-1:0] ramp_rate_i,
  input  logic [COUNT_BITS-1:0] pulse_ticks_i,
  input  logic [COUNT_BITS-1:0] period_ticks_i,
  output pgls_pkg::pgls_stat_t  stat_o
);

  localparam int CmpW = SAMPLE_BITS + 4;
  localparam logic [COUNT_BITS-1:0] CntMax = '1;

  // input stage
  logic                   pend_q;
  logic [SAMPLE_BITS-1:0] sig_q;
  logic [SAMPLE_BITS-1:0] thr_q;
  logic                   en_q;

  // tick state
  pgls_pkg::pgls_phase_e  phase_q, phase_d;
  logic                   flag_q, flag_d;
  logic [COUNT_BITS-1:0]  acc_q, acc_d;
  logic [COUNT_BITS-1:0]  hold_q, hold_d;
  logic [COUNT_BITS-1:0]  pc_q, pc_d;

  // result stage
  logic                   out_valid_q;
  logic [DAC_BITS-1:0]    dac_q, dac_d;
  logic                   light_q, light_d;
  logic                   busy_q, busy_d;

  logic                   adv;
  logic                   in_acc;
  logic                   above;
  logic                   below;
  logic [CmpW-1:0]        sig_x10;
  logic [CmpW-1:0]        thr_x9;

  pgls_pkg::pgls_phase_e  phase1;
  logic [COUNT_BITS-1:0]  acc1;
  logic [COUNT_BITS-1:0]  hold1;
  logic                   pc_clr;
  logic                   do_off;
  logic                   do_gate;
  logic                   do_pulse;
  logic                   is_idle;
  logic                   is_gon;

  logic [COUNT_BITS-1:0]  rate_eff;
  logic [COUNT_BITS:0]    ramp_sum;
  logic                   ramp_done;
  logic [DAC_BITS-1:0]    ramp_level;
  logic [COUNT_BITS-1:0]  pc_base;

  assign adv          = pend_q && (!out_valid_q || out_if.ready);
  assign in_if.ready  = !pend_q || adv;
  assign in_acc       = in_if.valid && in_if.ready;

  // below: sig < floor(9*thr/10) is the same as 10*(sig+1) <= 9*thr
  assign sig_x10 = (CmpW'(sig_q) + CmpW'(1)) * CmpW'(10);
  assign thr_x9  = CmpW'(thr_q) * CmpW'(9);
  assign above   = (sig_q > thr_q);
  assign below   = (sig_x10 <= thr_x9);

  assign is_idle = (phase_q == pgls_pkg::PH_IDLE);
  assign is_gon  = (phase_q == pgls_pkg::PH_GON);

  // decide: phase flag and light start/stop while idle or gate-on; pulse end in pulse hold
  always_comb begin
    flag_d   = flag_q;
    do_off   = 1'b0;
    do_gate  = 1'b0;
    do_pulse = 1'b0;
    if (phase_q == pgls_pkg::PH_PHOLD) begin
      do_off = (hold_q >= pulse_ticks_i);
    end else if (is_idle || is_gon) begin
      if (above) flag_d = 1'b1;
      if (below) flag_d = 1'b0;
      if (!en_q) begin
        do_off = is_gon;
      end else begin
        unique case (stim_mode_i)
          pgls_pkg::MODE_HIGH_GATE: begin
            if (above && is_idle) do_gate = 1'b1;
            else if (below && is_gon) do_off = 1'b1;
          end
          pgls_pkg::MODE_LOW_GATE: begin
            if (above && is_gon) do_off = 1'b1;
            else if (below && is_idle) do_gate = 1'b1;
          end
          pgls_pkg::MODE_LOW_TRAIN, pgls_pkg::MODE_FREE_TRAIN: begin
            if (is_gon) begin
              do_off = 1'b1;
            end else if ((stim_mode_i == pgls_pkg::MODE_FREE_TRAIN || !flag_d) &&
                         pc_q >= period_ticks_i) begin
              do_pulse = 1'b1;
            end
          end
        endcase
      end
    end
  end

  always_comb begin
    phase1 = phase_q;
    acc1   = acc_q;
    hold1  = hold_q;
    pc_clr = 1'b0;
    priority if (do_off) begin
      acc1   = '0;
      phase1 = ramp_shape_i ? pgls_pkg::PH_FALL : pgls_pkg::PH_IDLE;
    end else if (do_gate) begin
      acc1   = '0;
      hold1  = '0;
      phase1 = ramp_shape_i ? pgls_pkg::PH_GRISE : pgls_pkg::PH_GON;
    end else if (do_pulse) begin
      acc1   = '0;
      hold1  = '0;
      phase1 = ramp_shape_i ? pgls_pkg::PH_PRISE : pgls_pkg::PH_PHOLD;
      pc_clr = 1'b1;
    end else begin
      phase1 = phase_q;
    end
  end

  assign rate_eff  = (ramp_rate_i == '0) ? COUNT_BITS'(1) : ramp_rate_i;
  assign ramp_sum  = {1'b0, acc1} + {1'b0, rate_eff};
  assign ramp_done = ramp_sum[COUNT_BITS];

  pgls_ramp_shaper #(
    .DAC_BITS   (DAC_BITS),
    .COUNT_BITS (COUNT_BITS),
    .RAMP_STEPS (RAMP_STEPS)
  ) u_shaper (
    .acc_i        (acc1),
    .fall_i       (phase1 == pgls_pkg::PH_FALL),
    .on_level_i   (on_level_i),
    .base_level_i (base_level_i),
    .level_o      (ramp_level)
  );

  // light output and ramp/hold advance
  always_comb begin
    phase_d = phase1;
    acc_d   = acc1;
    hold_d  = hold1;
    dac_d   = '0;
    unique case (phase1)
      pgls_pkg::PH_GRISE, pgls_pkg::PH_PRISE: begin
        dac_d = ramp_level;
        if (ramp_done) begin
          acc_d   = '0;
          hold_d  = '0;
          phase_d = (phase1 == pgls_pkg::PH_PRISE) ? pgls_pkg::PH_PHOLD : pgls_pkg::PH_GON;
        end else begin
          acc_d = ramp_sum[COUNT_BITS-1:0];
        end
      end
      pgls_pkg::PH_GON: begin
        dac_d = on_level_i;
      end
      pgls_pkg::PH_PHOLD: begin
        dac_d = on_level_i;
        if (hold1 != CntMax) hold_d = hold1 + COUNT_BITS'(1);
      end
      pgls_pkg::PH_FALL: begin
        dac_d = ramp_level;
        if (ramp_done) begin
          acc_d   = '0;
          phase_d = pgls_pkg::PH_IDLE;
        end else begin
          acc_d = ramp_sum[COUNT_BITS-1:0];
        end
      end
      default: begin
        dac_d = ramp_shape_i ? base_level_i : '0;
      end
    endcase
  end

  // period counter: saturating enabled ticks since pulse start; disable clears or presets
  always_comb begin
    pc_base = pc_clr ? '0 : pc_q;
    if (!en_q) begin
      pc_d = (stim_mode_i == pgls_pkg::MODE_FREE_TRAIN) ? period_ticks_i : '0;
    end else if (pc_base != CntMax) begin
      pc_d = pc_base + COUNT_BITS'(1);
    end else begin
      pc_d = pc_base;
    end
  end

  assign light_d = (phase_d != pgls_pkg::PH_IDLE);
  assign busy_d  = (phase_d == pgls_pkg::PH_GRISE) || (phase_d == pgls_pkg::PH_PRISE) ||
                   (phase_d == pgls_pkg::PH_PHOLD) || (phase_d == pgls_pkg::PH_FALL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= pgls_pkg::PH_IDLE;
      flag_q      <= 1'b0;
      acc_q       <= '0;
      hold_q      <= '0;
      pc_q        <= '0;
    end else begin
      if (in_acc) begin
        pend_q <= 1'b1;
      end else if (adv) begin
        pend_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
        phase_q     <= phase_d;
        flag_q      <= flag_d;
        acc_q       <= acc_d;
        hold_q      <= hold_d;
        pc_q        <= pc_d;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload: load the input word on accept, the result word on advance
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sig_q <= in_if.signal_sample;
      thr_q <= in_if.threshold_sample;
      en_q  <= in_if.enable;
    end
    if (adv) begin
      dac_q   <= dac_d;
      light_q <= light_d;
      busy_q  <= busy_d;
    end
  end

  assign out_if.valid      = out_valid_q;
  assign out_if.dac_code   = dac_q;
  assign out_if.light_on   = light_q;
  assign out_if.high_phase = flag_q;
  assign out_if.busy_res   = busy_q;

  assign stat_o.pend  = pend_q;
  assign stat_o.phase = phase_q;

endmodule

`default_nettype wire

// File: rtl/core/phasic_gated_laser_stimulator_top.sv
// Channel  Dir  Handshake     Word
// in_if    in   valid/ready   signal_sample, threshold_sample, enable
// out_if   out  valid/ready   dac_code, light_on, high_phase, busy_res
// cfg      in   cfg_we_i      cfg_idx_i selects the register, cfg_data_i
//
// Throughput is one word per cycle while results are taken; an accepted word passes the input
// register, then the result register. The rate rests on the state update in the step engine.
// Reset is asynchronous, active low: registers return to defaults, light idle.
// A stalled result holds the step engine; one more word waits in the input register.
`timescale 1ns / 1ps
`default_nettype none

`include "phasic_gated_laser_stimulator_top_macros.svh"

module phasic_gated_laser_stimulator_top #(
  parameter int SAMPLE_BITS = pgls_pkg::DEF_SAMPLE_BITS,
  parameter int DAC_BITS    = pgls_pkg::DEF_DAC_BITS,
  parameter int COUNT_BITS  = pgls_pkg::DEF_COUNT_BITS,
  parameter int RAMP_STEPS  = pgls_pkg::DEF_RAMP_STEPS,
  localparam int CfgW       = (COUNT_BITS > DAC_BITS) ? COUNT_BITS : DAC_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  pgls_in_if.sink                        in_if,
  pgls_out_if.source                     out_if,
  input  logic                           cfg_we_i,
  input  logic [pgls_pkg::REG_IDX_W-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]                cfg_data_i
);

  pgls_pkg::pgls_mode_e  stim_mode_q;
  logic                  ramp_shape_q;
  logic [DAC_BITS-1:0]   on_level_q;
  logic [DAC_BITS-1:0]   base_level_q;
  logic [COUNT_BITS-1:0] ramp_rate_q;
  logic [COUNT_BITS-1:0] pulse_ticks_q;
  logic [COUNT_BITS-1:0] period_ticks_q;
  pgls_pkg::pgls_stat_t  stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stim_mode_q    <= pgls_pkg::MODE_HIGH_GATE;
      ramp_shape_q   <= 1'b1;
      on_level_q     <= DAC_BITS'(pgls_pkg::RST_ON_LEVEL);
      base_level_q   <= DAC_BITS'(pgls_pkg::RST_BASE_LEVEL);
      ramp_rate_q    <= COUNT_BITS'(pgls_pkg::RST_RAMP_RATE);
      pulse_ticks_q  <= COUNT_BITS'(pgls_pkg::RST_PULSE_TICKS);
      period_ticks_q <= COUNT_BITS'(pgls_pkg::RST_PERIOD_TICKS);
    end else if (cfg_we_i) begin
      unique case (pgls_pkg::pgls_reg_e'(cfg_idx_i))
        pgls_pkg::REG_STIM_MODE:    stim_mode_q    <= pgls_pkg::pgls_mode_e'(cfg_data_i[1:0]);
        pgls_pkg::REG_RAMP_SHAPE:   ramp_shape_q   <= cfg_data_i[0];
        pgls_pkg::REG_ON_LEVEL:     on_level_q     <= cfg_data_i[DAC_BITS-1:0];
        pgls_pkg::REG_BASE_LEVEL:   base_level_q   <= cfg_data_i[DAC_BITS-1:0];
        pgls_pkg::REG_RAMP_RATE:    ramp_rate_q    <= cfg_data_i[COUNT_BITS-1:0];
        pgls_pkg::REG_PULSE_TICKS:  pulse_ticks_q  <= cfg_data_i[COUNT_BITS-1:0];
        pgls_pkg::REG_PERIOD_TICKS: period_ticks_q <= cfg_data_i[COUNT_BITS-1:0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  pgls_step_engine #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .DAC_BITS    (DAC_BITS),
    .COUNT_BITS  (COUNT_BITS),
    .RAMP_STEPS  (RAMP_STEPS)
  ) u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_if          (in_if),
    .out_if         (out_if),
    .stim_mode_i    (stim_mode_q),
    .ramp_shape_i   (ramp_shape_q),
    .on_level_i     (on_level_q),
    .base_level_i   (base_level_q),
    .ramp_rate_i    (ramp_rate_q),
    .pulse_ticks_i  (pulse_ticks_q),
    .period_ticks_i (period_ticks_q),
    .stat_o         (stat)
  );

  `PGLS_ASSERT_IMP(a_busy_lit, clk_i, rst_ni, out_if.valid && out_if.busy_res, out_if.light_on, "busy result with light off")
  `PGLS_ASSERT_NXT(a_stall_keep, clk_i, rst_ni, out_if.valid && !out_if.ready && stat.pend, stat.pend, "pending word lost under stall")
  `PGLS_ASSERT_NXT(a_stall_phase, clk_i, rst_ni, out_if.valid && !out_if.ready, $stable(stat.phase), "light phase moved under stall")

endmodule

`default_nettype wire

// File: sim/phasic_gated_laser_stimulator_top_test.sv
`timescale 1ns / 1ps

module phasic_gated_laser_stimulator_top_test;
  import pgls_pkg::*;

  localparam int SMP_W   = DEF_SAMPLE_BITS;
  localparam int DAC_W   = DEF_DAC_BITS;
  localparam int CNT_W   = DEF_COUNT_BITS;
  localparam int STEPS   = DEF_RAMP_STEPS;
  localparam int IDX_LSB = CNT_W - $clog2(STEPS);
  localparam int CFG_W   = (CNT_W > DAC_W) ? CNT_W : DAC_W;
  localparam longint unsigned Q30 = 64'd1 << 30;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam int N_PHASES  = 8;
  localparam int PHASE_LEN = 90;
  localparam int MAX_SHOWN = 10;

  typedef struct packed {
    logic [DAC_W-1:0] dac_code;
    logic             light_on;
    logic             high_phase;
    logic             busy_res;
  } laser_word_t;

  typedef struct {
    bit               is_write;
    pgls_reg_e        reg_idx;
    int unsigned      value;
    logic [SMP_W-1:0] sig;
    logic [SMP_W-1:0] thr;
    logic             en;
    bit               typed;
    laser_word_t      want;
  } plan_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [REG_IDX_W-1:0] cfg_idx_i = REG_STIM_MODE;
  logic [CFG_W-1:0] cfg_data_i = '0;

  pgls_in_if  #(.SAMPLE_BITS(SMP_W)) in_ch ();
  pgls_out_if #(.DAC_BITS(DAC_W))    out_ch ();

  phasic_gated_laser_stimulator_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_ch),
    .out_if     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Shadow registers and stimulator state
  pgls_mode_e       cfg_mode    = MODE_HIGH_GATE;
  logic             cfg_sigmoid = 1'b1;
  logic [DAC_W-1:0] cfg_on      = DAC_W'(RST_ON_LEVEL);
  logic [DAC_W-1:0] cfg_base    = DAC_W'(RST_BASE_LEVEL);
  logic [CNT_W-1:0] cfg_rate    = CNT_W'(RST_RAMP_RATE);
  logic [CNT_W-1:0] cfg_pulse   = CNT_W'(RST_PULSE_TICKS);
  logic [CNT_W-1:0] cfg_period  = CNT_W'(RST_PERIOD_TICKS);

  logic             flag_q     = 1'b0;
  pgls_phase_e      light_st   = PH_IDLE;
  logic [CNT_W:0]   ramp_acc   = '0;
  logic [CNT_W-1:0] hold_cnt   = '0;
  logic [CNT_W-1:0] period_cnt = '0;
  int unsigned      sigmoid_lut [STEPS];

  laser_word_t dac_expect_q [$];
  plan_row_t   plan_q [$];
  laser_word_t predicted;
  bit          cur_typed = 1'b0;
  laser_word_t cur_want = '0;
  int n_accepted = 0;
  int n_checked = 0;
  int n_errors = 0;
  int n_writes = 0;
  int n_lit = 0;
  int burst_left = 0;
  bit long_hold_done = 1'b0;

  function automatic void build_sigmoid();
    longint unsigned a, b, p, y, y2, y3, y4, e, den, num;
    bit pos;
    for (int i = 0; i < STEPS; i++) begin
      a   = longint'(i) * 10;
      b   = longint'(STEPS) * 5;
      pos = (a >= b);
      p   = pos ? a - b : b - a;
      y   = (p << 30) / (64 * STEPS);
      y2  = (y * y) >> 30;
      y3  = (y2 * y) >> 30;
      y4  = (y3 * y) >> 30;
      e   = (Q30 + y2 / 2 + y4 / 24) - (y + y3 / 6);
      repeat (6) e = (e * e) >> 30;
      den = Q30 + e;
      num = pos ? (Q30 << DAC_W) : (e << DAC_W);
      sigmoid_lut[i] = int'((num + den / 2) / den);
    end
  endfunction

  // Blend between base and on level, rounding half up; works for inverted levels too
  function automatic logic [DAC_W-1:0] level_at(input int unsigned frac);
    int unsigned on_v, base_v;
    on_v   = cfg_on;
    base_v = cfg_base;
    if (on_v >= base_v)
      return DAC_W'(base_v + (((on_v - base_v) * frac + (1 << (DAC_W - 1))) >> DAC_W));
    return DAC_W'(base_v - (((base_v - on_v) * frac + (1 << (DAC_W - 1))) >> DAC_W));
  endfunction

  function automatic void light_up(input bit is_pulse);
    ramp_acc = '0;
    hold_cnt = '0;
    if (cfg_sigmoid) light_st = is_pulse ? PH_PRISE : PH_GRISE;
    else             light_st = is_pulse ? PH_PHOLD : PH_GON;
  endfunction

  function automatic void light_down();
    ramp_acc = '0;
    light_st = cfg_sigmoid ? PH_FALL : PH_IDLE;
  endfunction

  function automatic bit ramp_done();
    ramp_acc = ramp_acc + ((cfg_rate == '0) ? 1 : cfg_rate);
    if (ramp_acc >= (1 << CNT_W)) begin
      ramp_acc = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic laser_word_t step_stimulator(input logic [SMP_W-1:0] sig,
                                                  input logic [SMP_W-1:0] thr,
                                                  input logic en);
    bit          above, below;
    logic [DAC_W-1:0] dac;
    laser_word_t res;
    above = sig > thr;
    below = int'(sig) < (int'(thr) * 9) / 10;
    dac   = '0;

    // Decisions only in idle or gate-on; ramps and timed pulses run to completion
    if (light_st == PH_PHOLD) begin
      if (hold_cnt >= cfg_pulse) light_down();
    end else if (light_st == PH_IDLE || light_st == PH_GON) begin
      if (above) flag_q = 1'b1;
      if (below) flag_q = 1'b0;
      if (!en) begin
        if (light_st == PH_GON) light_down();
      end else if (cfg_mode == MODE_HIGH_GATE) begin
        if (above && light_st == PH_IDLE) light_up(1'b0);
        else if (below && light_st == PH_GON) light_down();
      end else if (cfg_mode == MODE_LOW_GATE) begin
        if (above && light_st == PH_GON) light_down();
        else if (below && light_st == PH_IDLE) light_up(1'b0);
      end else if (light_st == PH_GON) begin
        light_down();
      end else if ((cfg_mode == MODE_FREE_TRAIN || !flag_q) && period_cnt >= cfg_period) begin
        light_up(1'b1);
        period_cnt = '0;
      end
    end

    case (light_st)
      PH_GRISE, PH_PRISE: begin
        dac = level_at(sigmoid_lut[ramp_acc[CNT_W-1:IDX_LSB]]);
        if (ramp_done()) begin
          hold_cnt = '0;
          light_st = (light_st == PH_PRISE) ? PH_PHOLD : PH_GON;
        end
      end
      PH_GON: dac = cfg_on;
      PH_PHOLD: begin
        dac = cfg_on;
        if (hold_cnt != CNT_MAX) hold_cnt = hold_cnt + 1'b1;
      end
      PH_FALL: begin
        dac = level_at((1 << DAC_W) - sigmoid_lut[ramp_acc[CNT_W-1:IDX_LSB]]);
        if (ramp_done()) light_st = PH_IDLE;
      end
      default: dac = cfg_sigmoid ? cfg_base : '0;
    endcase

    if (!en) period_cnt = (cfg_mode == MODE_FREE_TRAIN) ? cfg_period : '0;
    else if (period_cnt != CNT_MAX) period_cnt = period_cnt + 1'b1;

    res.dac_code   = dac;
    res.light_on   = (light_st != PH_IDLE);
    res.high_phase = flag_q;
    res.busy_res   = (light_st == PH_GRISE || light_st == PH_PRISE ||
                      light_st == PH_PHOLD || light_st == PH_FALL);
    return res;
  endfunction

  // Predict at acceptance of each input word
  always @(posedge clk_i) begin
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      predicted = step_stimulator(in_ch.signal_sample, in_ch.threshold_sample, in_ch.enable);
      dac_expect_q.push_back(cur_typed ? cur_want : predicted);
      n_accepted++;
    end
  end

  task automatic report_mismatch(input string what, input laser_word_t want,
                                 input laser_word_t got);
    n_errors++;
    if (n_errors <= MAX_SHOWN)
      $display("%0t: %s: expected dac=%0d on=%0b high=%0b busy=%0b, got dac=%0d on=%0b high=%0b busy=%0b",
               $realtime, what, want.dac_code, want.light_on, want.high_phase, want.busy_res,
               got.dac_code, got.light_on, got.high_phase, got.busy_res);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (out_ch.light_on) n_lit++;
      if (dac_expect_q.size() == 0) begin
        report_mismatch("unexpected result word", '0,
                        {out_ch.dac_code, out_ch.light_on, out_ch.high_phase, out_ch.busy_res});
      end else begin
        if (dac_expect_q[0].dac_code != out_ch.dac_code ||
            dac_expect_q[0].light_on != out_ch.light_on ||
            dac_expect_q[0].high_phase != out_ch.high_phase ||
            dac_expect_q[0].busy_res != out_ch.busy_res)
          report_mismatch($sformatf("word %0d mismatch", n_checked), dac_expect_q[0],
                          {out_ch.dac_code, out_ch.light_on, out_ch.high_phase, out_ch.busy_res});
        void'(dac_expect_q.pop_front());
        n_checked++;
      end
    end
  end

  // Receiver: changing stall patterns, plus one long hold-off to back up the input
  initial begin
    int pat, pat_left, rx_tick;
    pat = 0;
    pat_left = 0;
    rx_tick = 0;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!long_hold_done && n_accepted >= 320) begin
        long_hold_done = 1'b1;
        out_ch.ready = 1'b0;
        repeat (300) @(negedge clk_i);
      end
      if (pat_left == 0) begin
        pat = $urandom_range(0, 3);
        pat_left = $urandom_range(8, 64);
      end
      pat_left--;
      rx_tick++;
      case (pat)
        0:       out_ch.ready = 1'b1;
        1:       out_ch.ready = $urandom_range(0, 1);
        2:       out_ch.ready = (rx_tick % 4 == 0);
        default: out_ch.ready = ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  task automatic send_word(input logic [SMP_W-1:0] s, input logic [SMP_W-1:0] t,
                           input logic e, input bit typed, input laser_word_t want);
    @(negedge clk_i);
    cur_typed = typed;
    cur_want = want;
    in_ch.valid = 1'b1;
    in_ch.signal_sample = s;
    in_ch.threshold_sample = t;
    in_ch.enable = e;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  // Keep valid up within a burst, drop it for a random gap between bursts
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 6);
      burst_left = $urandom_range(0, 24);
      @(negedge clk_i);
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_ch.valid = 1'b0;
    wait (n_checked == n_accepted);
  endtask

  task automatic write_reg(input pgls_reg_e idx, input int unsigned val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = CFG_W'(val);
    case (idx)
      REG_STIM_MODE:    cfg_mode = pgls_mode_e'(val[1:0]);
      REG_RAMP_SHAPE:   cfg_sigmoid = val[0];
      REG_ON_LEVEL:     cfg_on = DAC_W'(val);
      REG_BASE_LEVEL:   cfg_base = DAC_W'(val);
      REG_RAMP_RATE:    cfg_rate = CNT_W'(val);
      REG_PULSE_TICKS:  cfg_pulse = CNT_W'(val);
      REG_PERIOD_TICKS: cfg_period = CNT_W'(val);
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    n_writes++;
  endtask

  function automatic void add_write(input pgls_reg_e idx, input int unsigned val);
    plan_row_t row;
    row = '{is_write: 1'b1, reg_idx: idx, value: val, sig: '0, thr: '0, en: 1'b0,
            typed: 1'b0, want: '0};
    plan_q.push_back(row);
  endfunction

  function automatic void add_tick(input int s, input int t, input bit e,
                                   input bit typed = 1'b0, input laser_word_t want = '0);
    plan_row_t row;
    row = '{is_write: 1'b0, reg_idx: REG_STIM_MODE, value: 0, sig: SMP_W'(s), thr: SMP_W'(t),
            en: e, typed: typed, want: want};
    plan_q.push_back(row);
  endfunction

  function automatic int unsigned pick(input int unsigned lo, input int unsigned hi,
                                       input int unsigned typ_lo, input int unsigned typ_hi);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return lo;
    if (r == 1) return hi;
    return $urandom_range(typ_lo, typ_hi);
  endfunction

  initial begin
    int thr, sig, floor9, r;
    bit sig_high, en;
    build_sigmoid();
    in_ch.valid = 1'b0;
    in_ch.signal_sample = '0;
    in_ch.threshold_sample = '0;
    in_ch.enable = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset defaults: idle at base level, flag follows the comparator even when disabled
    add_tick(0, 0, 1, 1, '{12'd0, 1'b0, 1'b0, 1'b0});
    add_tick(4095, 0, 0, 1, '{12'd0, 1'b0, 1'b1, 1'b0});
    add_tick(0, 4095, 0, 1, '{12'd0, 1'b0, 1'b0, 1'b0});
    // High-phase gate with two-tick sigmoid edges, then enable drop mid gate-on
    add_write(REG_RAMP_RATE, 24'hFFFFFF);
    add_tick(4095, 100, 1);
    add_tick(4095, 100, 1);
    add_tick(4095, 100, 1);
    add_tick(0, 4095, 0);
    add_tick(0, 4095, 1);
    // Low-phase gate with step edges and inverted levels
    add_write(REG_STIM_MODE, MODE_LOW_GATE);
    add_write(REG_RAMP_SHAPE, 0);
    add_write(REG_ON_LEVEL, 100);
    add_write(REG_BASE_LEVEL, 4000);
    add_tick(0, 4095, 1);
    add_tick(4095, 0, 1);
    add_write(REG_RAMP_SHAPE, 1);
    add_tick(10, 4095, 1);
    add_tick(10, 4095, 1);
    // Switch to low-phase train while gate-on; zero period and zero pulse length
    add_write(REG_STIM_MODE, MODE_LOW_TRAIN);
    add_write(REG_PERIOD_TICKS, 0);
    add_write(REG_PULSE_TICKS, 0);
    add_tick(10, 4095, 1);
    add_tick(10, 4095, 1);
    add_tick(10, 4095, 1);
    add_tick(10, 4095, 1);
    add_tick(10, 4095, 1);
    // Edge shape changed mid-fall
    add_write(REG_RAMP_SHAPE, 0);
    add_tick(10, 4095, 1);
    // Free train: disabled tick preloads the period counter, then a short pulse
    add_write(REG_STIM_MODE, MODE_FREE_TRAIN);
    add_write(REG_PERIOD_TICKS, 3);
    add_write(REG_PULSE_TICKS, 2);
    add_tick(10, 4095, 0);
    add_tick(4095, 0, 1);
    add_tick(4095, 0, 1);
    add_tick(4095, 0, 1);
    // Zero ramp rate crawls; release it with the fastest rate
    add_write(REG_STIM_MODE, MODE_HIGH_GATE);
    add_write(REG_RAMP_SHAPE, 1);
    add_write(REG_ON_LEVEL, 4095);
    add_write(REG_BASE_LEVEL, 0);
    add_write(REG_RAMP_RATE, 0);
    add_tick(4095, 0, 1);
    add_write(REG_RAMP_RATE, 24'hFFFFFF);
    add_tick(4095, 0, 1);
    add_tick(4095, 4095, 1);

    foreach (plan_q[i]) begin
      if (plan_q[i].is_write) begin
        settle();
        write_reg(plan_q[i].reg_idx, plan_q[i].value);
      end else begin
        send_word(plan_q[i].sig, plan_q[i].thr, plan_q[i].en, plan_q[i].typed,
                  plan_q[i].want);
        pace();
      end
    end

    sig_high = 1'b0;
    for (int ph = 0; ph < N_PHASES; ph++) begin
      settle();
      write_reg(REG_STIM_MODE, ph % 4);
      write_reg(REG_RAMP_SHAPE, (ph % 3) != 0);
      write_reg(REG_ON_LEVEL, pick(0, 4095, 0, 4095));
      write_reg(REG_BASE_LEVEL, pick(0, 4095, 0, 4095));
      write_reg(REG_RAMP_RATE, ($urandom_range(0, 9) == 0) ? 24'hFFFFFF
                                : 24'hFFFFFF / $urandom_range(1, 12));
      write_reg(REG_PULSE_TICKS, pick(0, 24'hFFFFFF, 0, 12));
      write_reg(REG_PERIOD_TICKS, pick(1, 24'hFFFFFF, 0, 30));
      for (int k = 0; k < PHASE_LEN; k++) begin
        // Hold the signal regime for a while so gates and trains get to run
        if ($urandom_range(0, 9) == 0) sig_high = !sig_high;
        thr = $urandom_range(0, 4095);
        floor9 = (thr * 9) / 10;
        r = $urandom_range(0, 9);
        if (r == 0) sig = $urandom_range(0, 4095);
        else if (r == 1) sig = $urandom_range(floor9, thr);
        else if (sig_high) sig = (thr == 4095) ? 4095 : $urandom_range(thr + 1, 4095);
        else sig = (floor9 == 0) ? 0 : $urandom_range(0, floor9 - 1);
        en = ($urandom_range(0, 14) != 0);
        send_word(SMP_W'(sig), SMP_W'(thr), en, 1'b0, '0);
        pace();
      end
    end

    settle();
    repeat (10) @(posedge clk_i);
    if (dac_expect_q.size() != 0) begin
      n_errors++;
      $display("%0d expected words never arrived", dac_expect_q.size());
    end
    $display("Run covered %0d words (%0d with light on), %0d register writes, %0d settings",
             n_checked, n_lit, n_writes, N_PHASES);
    $display("Mismatches: %0d", n_errors);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout waiting for result words");
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/pgls_pkg.sv
rtl/core/pgls_if.sv
rtl/core/pgls_ramp_shaper.sv
rtl/core/pgls_step_engine.sv
rtl/core/phasic_gated_laser_stimulator_top.sv
sim/phasic_gated_laser_stimulator_top_test.sv
